// File: rtl/cli_pkg.sv
`timescale 1ns / 1ps
package cli_pkg;

  // result status carried with every transaction
  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_SAME = 2'd2
  } status_t;

  // register indexes (byte address bits [3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_CENTER_X = 2'd0;
  localparam reg_idx_t REG_CENTER_Y = 2'd1;
  localparam reg_idx_t REG_RADIUS   = 2'd2;

endpackage

// File: rtl/circle_line_intersection.sv
`timescale 1ns / 1ps
// Throughput: one line per cycle while the output register is empty or taken.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// circle registers with center (8000, 8000) and radius 1600.
module circle_line_intersection #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: start_x, start_y, end_x, end_y (lowest first)
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  // out_tdata: first_x, first_y, second_x, second_y (lowest first)
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // out_tuser: status
  output cli_pkg::status_t                      out_tuser,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [3:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import cli_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int TDW  = ((4 * W + 7) / 8) * 8;
  localparam int AW   = W + 1;
  localparam int NW   = 2 * W + 2;
  localparam int CW   = 2 * W + 3;
  localparam int TW   = 2 * W + 1;
  localparam int DW   = 4 * W;
  localparam int IT   = 2 * W;
  localparam int PW   = 3 * W + 2;
  localparam int NUMW = 3 * W + 3;
  localparam int QB   = W + 1;
  localparam logic [QB-1:0] QMAX = QB'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QB-1:0] QMIN = QB'(64'd1 << (W - 1));

  // ---------------- configuration registers ----------------
  logic [W-1:0] center_x_r, center_y_r;
  logic [W-2:0] radius_r;
  logic         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= W'(8000);
      center_y_r <= W'(8000);
      radius_r   <= (W-1)'(1600);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_CENTER_X: center_x_r <= cfg_pwdata[W-1:0];
        REG_CENTER_Y: center_y_r <= cfg_pwdata[W-1:0];
        REG_RADIUS:   radius_r   <= cfg_pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CENTER_X: cfg_prdata = 32'(center_x_r);
      REG_CENTER_Y: cfg_prdata = 32'(center_y_r);
      REG_RADIUS:   cfg_prdata = 32'(radius_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  logic en;
  logic out_valid_r;

  assign en        = ~out_valid_r | out_tready;
  assign in_tready = en;

  // ---------------- stage 1: line direction and offset ----------------
  logic signed [W-1:0]  sx, sy, ex, ey;
  logic signed [AW-1:0] a1_r, b1_r, rx1_r, ry1_r;
  logic                 v1_r;

  assign sx = $signed(in_tdata[W-1:0]);
  assign sy = $signed(in_tdata[2*W-1:W]);
  assign ex = $signed(in_tdata[3*W-1:2*W]);
  assign ey = $signed(in_tdata[4*W-1:3*W]);

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= AW'(ey) - AW'(sy);
      b1_r  <= AW'(sx) - AW'(ex);
      rx1_r <= AW'(sx) - AW'($signed(center_x_r));
      ry1_r <= AW'(sy) - AW'($signed(center_y_r));
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [2*AW-1:0] aa_w, bb_w, arx_w, bry_w;
  logic signed [2*AW-1:0] aa2_r, bb2_r, arx2_r, bry2_r;
  logic [2*W-3:0]         rr2_r;
  logic signed [AW-1:0]   a2_r, b2_r;
  logic                   v2_r;

  assign aa_w  = a1_r * a1_r;
  assign bb_w  = b1_r * b1_r;
  assign arx_w = a1_r * rx1_r;
  assign bry_w = b1_r * ry1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aa2_r  <= aa_w;
      bb2_r  <= bb_w;
      arx2_r <= arx_w;
      bry2_r <= bry_w;
      rr2_r  <= radius_r * radius_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
    end
  end

  // ---------------- stage 3: n and c ----------------
  logic [NW-1:0]        n3_r;
  logic signed [CW-1:0] c3_r;
  logic                 same3_r;
  logic [2*W-3:0]       rr3_r;
  logic signed [AW-1:0] a3_r, b3_r;
  logic                 v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r    <= NW'($unsigned(aa2_r)) + NW'($unsigned(bb2_r));
      c3_r    <= -(CW'(arx2_r) + CW'(bry2_r));
      same3_r <= (a2_r == '0) && (b2_r == '0);
      rr3_r   <= rr2_r;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
    end
  end

  // ---------------- stage 4: c squared and r^2 * n ----------------
  logic [CW-1:0]        cabs_w;
  logic [DW-1:0]        c2_w, lim_w;
  logic [DW-1:0]        c2_4_r, lim4_r;
  logic                 big4_r, same4_r;
  logic signed [TW-1:0] ct4_r;
  logic [NW-1:0]        n4_r;
  logic signed [AW-1:0] a4_r, b4_r;
  logic                 v4_r;

  assign cabs_w = c3_r[CW-1] ? $unsigned(-c3_r) : $unsigned(c3_r);
  assign c2_w   = cabs_w[2*W-1:0] * cabs_w[2*W-1:0];
  assign lim_w  = rr3_r * n3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_4_r  <= c2_w;
      lim4_r  <= lim_w;
      big4_r  <= |cabs_w[CW-1:2*W];
      same4_r <= same3_r;
      ct4_r   <= c3_r[TW-1:0];
      n4_r    <= n3_r;
      a4_r    <= a3_r;
      b4_r    <= b3_r;
    end
  end

  // ---------------- stage 5: classify, chord term ----------------
  logic [DW-1:0]        d5_r;
  status_t              status5_r;
  logic signed [TW-1:0] ct5_r;
  logic [NW-1:0]        n5_r;
  logic signed [AW-1:0] a5_r, b5_r;
  logic                 v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d5_r <= lim4_r - c2_4_r;
      if (same4_r) begin
        status5_r <= ST_SAME;
      end else if (big4_r || (c2_4_r > lim4_r)) begin
        status5_r <= ST_MISS;
      end else begin
        status5_r <= ST_HIT;
      end
      ct5_r <= ct4_r;
      n5_r  <= n4_r;
      a5_r  <= a4_r;
      b5_r  <= b4_r;
    end
  end

  // ---------------- square root with side data ----------------
  logic [2*W-1:0]       root_w;
  logic signed [AW-1:0] aq_r [IT];
  logic signed [AW-1:0] bq_r [IT];
  logic signed [TW-1:0] ctq_r [IT];
  logic [NW-1:0]        nq_r [IT];
  status_t              stq_r [IT];
  logic [IT-1:0]        vq_r;

  cli_isqrt #(.DW(DW)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .d    (d5_r),
    .root (root_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      aq_r[0]  <= a5_r;
      bq_r[0]  <= b5_r;
      ctq_r[0] <= ct5_r;
      nq_r[0]  <= n5_r;
      stq_r[0] <= status5_r;
      for (int k = 1; k < IT; k++) begin
        aq_r[k]  <= aq_r[k-1];
        bq_r[k]  <= bq_r[k-1];
        ctq_r[k] <= ctq_r[k-1];
        nq_r[k]  <= nq_r[k-1];
        stq_r[k] <= stq_r[k-1];
      end
    end
  end

  // ---------------- stage 6: numerator products ----------------
  logic signed [2*W:0]  s_w;
  logic signed [PW-1:0] ac_w, bs_w, bc_w, as_w;
  logic signed [PW-1:0] ac6_r, bs6_r, bc6_r, as6_r;
  logic [NW-1:0]        n6_r;
  status_t              status6_r;
  logic                 v6_r;

  assign s_w  = $signed({1'b0, root_w});
  assign ac_w = aq_r[IT-1] * ctq_r[IT-1];
  assign bc_w = bq_r[IT-1] * ctq_r[IT-1];
  assign bs_w = bq_r[IT-1] * s_w;
  assign as_w = aq_r[IT-1] * s_w;

  always_ff @(posedge clk) begin
    if (en) begin
      ac6_r     <= ac_w;
      bs6_r     <= bs_w;
      bc6_r     <= bc_w;
      as6_r     <= as_w;
      n6_r      <= nq_r[IT-1];
      status6_r <= stq_r[IT-1];
    end
  end

  // ---------------- stage 7: numerators ----------------
  logic signed [NUMW-1:0] num7_r [4];
  logic [NW-1:0]          n7_r;
  status_t                status7_r;
  logic                   v7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num7_r[0] <= NUMW'(bs6_r) - NUMW'(ac6_r);
      num7_r[1] <= -NUMW'(bc6_r) - NUMW'(as6_r);
      num7_r[2] <= -NUMW'(ac6_r) - NUMW'(bs6_r);
      num7_r[3] <= NUMW'(as6_r) - NUMW'(bc6_r);
      n7_r      <= n6_r;
      status7_r <= status6_r;
    end
  end

  // ---------------- stage 8: magnitude plus half divisor ----------------
  logic [NUMW-1:0] mag8_r [4];
  logic [3:0]      neg8_r;
  logic [NW-1:0]   n8_r;
  status_t         status8_r;
  logic            v8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg8_r[i] <= num7_r[i][NUMW-1];
        mag8_r[i] <= (num7_r[i][NUMW-1] ? $unsigned(-num7_r[i]) : $unsigned(num7_r[i]))
                     + NUMW'(n7_r >> 1);
      end
      n8_r      <= n7_r;
      status8_r <= status7_r;
    end
  end

  // ---------------- dividers with side data ----------------
  logic [QB-1:0] quot_w [4];
  logic [3:0]    negd_r [QB];
  status_t       std_r [QB];
  logic [QB-1:0] vd_r;

  genvar g;
  for (g = 0; g < 4; g++) begin : g_div
    cli_div #(.RW(NUMW), .NW(NW), .QB(QB)) u_div (
      .clk      (clk),
      .en       (en),
      .dividend (mag8_r[g]),
      .divisor  (n8_r),
      .quot     (quot_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negd_r[0] <= neg8_r;
      std_r[0]  <= status8_r;
      for (int k = 1; k < QB; k++) begin
        negd_r[k] <= negd_r[k-1];
        std_r[k]  <= std_r[k-1];
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vq_r <= '0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      vd_r <= '0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vq_r <= {vq_r[IT-2:0], v5_r};
      v6_r <= vq_r[IT-1];
      v7_r <= v6_r;
      v8_r <= v7_r;
      vd_r <= {vd_r[QB-2:0], v8_r};
    end
  end

  // ---------------- output: apply sign, saturate, zero non-hits ----------------
  logic [W-1:0]     coord_w [4];
  logic [TDW-1:0]   out_tdata_nxt;
  logic [TDW-1:0]   out_tdata_r;
  status_t          out_tuser_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (std_r[QB-1] != ST_HIT) begin
        coord_w[i] = '0;
      end else if (!negd_r[QB-1][i]) begin
        coord_w[i] = (quot_w[i] > QMAX) ? QMAX[W-1:0] : quot_w[i][W-1:0];
      end else begin
        coord_w[i] = (quot_w[i] > QMIN) ? QMIN[W-1:0] : W'(-quot_w[i][W-1:0]);
      end
    end
    out_tdata_nxt = TDW'({coord_w[3], coord_w[2], coord_w[1], coord_w[0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= std_r[QB-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- assertions ----------------
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_HIT) |-> (out_tdata == '0))
    else $error("non-hit result carries nonzero coordinates");

  a_hit_nonzero_n: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && status5_r == ST_HIT) |-> (n5_r != '0))
    else $error("hit classified with zero line norm");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

// File: rtl/cli_isqrt.sv
`timescale 1ns / 1ps
// Integer square root, one result bit per register stage.
module cli_isqrt #(
  parameter int DW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DW-1:0]   d,
  output logic [DW/2-1:0] root
);
  localparam int IT = DW / 2;

  logic [DW-1:0] x_r   [IT];
  logic [DW-1:0] res_r [IT];

  genvar k;
  for (k = 0; k < IT; k++) begin : g_stage
    logic [DW-1:0] xi, ri, bitc, trial, x_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign xi = d;
      assign ri = '0;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign ri = res_r[k-1];
    end

    assign bitc  = DW'(1) << (DW - 2 - 2 * k);
    assign trial = ri + bitc;

    // one digit of the root
    always_comb begin
      if (xi >= trial) begin
        x_nxt   = xi - trial;
        res_nxt = (ri >> 1) + bitc;
      end else begin
        x_nxt   = xi;
        res_nxt = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[IT-1][IT-1:0];

endmodule

// File: rtl/cli_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per register stage.
// Dividend must stay below divisor * 2**QB.
module cli_div #(
  parameter int RW = 51,
  parameter int NW = 34,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [QB-1:0] quot
);
  logic [RW-1:0] rem_r [QB];
  logic [NW-1:0] dvs_r [QB];
  logic [QB-1:0] q_r   [QB];

  genvar i;
  for (i = 0; i < QB; i++) begin : g_stage
    logic [RW-1:0] ri, dv, rem_nxt;
    logic [NW-1:0] di;
    logic [QB-1:0] qi, q_nxt;
    logic          take;

    if (i == 0) begin : g_first
      assign ri = dividend;
      assign di = divisor;
      assign qi = '0;
    end else begin : g_next
      assign ri = rem_r[i-1];
      assign di = dvs_r[i-1];
      assign qi = q_r[i-1];
    end

    assign dv      = RW'(di) << (QB - 1 - i);
    assign take    = (ri >= dv);
    assign rem_nxt = take ? (ri - dv) : ri;
    assign q_nxt   = {qi[QB-2:0], take};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        dvs_r[i] <= di;
        q_r[i]   <= q_nxt;
      end
    end
  end

  assign quot = q_r[QB-1];

endmodule

// File: tb/circle_line_intersection_test.sv
`timescale 1ns / 1ps
module circle_line_intersection_test;
  import cli_pkg::*;

  localparam int PIPE_WAIT = 80;   // longer than the DUT pipeline

  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    status_t            st;
  } cross_t;

  typedef struct {
    logic signed [15:0] x0, y0, x1, y1;
    bit                 typed;
    cross_t             want;
  } line_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  status_t     out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // circle as the testbench believes it to be
  logic signed [15:0] ctr_x = 16'sd8000;
  logic signed [15:0] ctr_y = 16'sd8000;
  logic [14:0]        rad = 15'd1600;

  cross_t    crossing_q[$];
  line_row_t dir_rows[$];
  int        err_cnt = 0;
  int        lines_sent = 0;
  int        hits_seen = 0, misses_seen = 0, sames_seen = 0;
  bit        no_idle = 1'b0;

  circle_line_intersection dut (.*);

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // nearest, ties away from zero, then clamp to the coordinate range
  function automatic logic signed [15:0] div_sat(input longint num, input longint den);
    longint unsigned mag, q;
    longint v;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + longint'(den) / 2) / longint'(den);
    v = (num < 0) ? -longint'(q) : longint'(q);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic cross_t chord_points(input logic signed [15:0] x0, y0, x1, y1);
    longint a, b, rx, ry, n, c, s;
    longint unsigned cabs, lim, rr;
    cross_t r;
    r = '{fx: 0, fy: 0, sx: 0, sy: 0, st: ST_HIT};
    a = longint'(y1) - longint'(y0);
    b = longint'(x0) - longint'(x1);
    if (a == 0 && b == 0) begin
      r.st = ST_SAME;
      return r;
    end
    rx = longint'(x0) - longint'(ctr_x);
    ry = longint'(y0) - longint'(ctr_y);
    n = a * a + b * b;
    c = -(a * rx + b * ry);
    cabs = (c < 0) ? longint'(-c) : c;
    rr = 64'(rad);
    lim = rr * rr * longint'(n);
    if (cabs >= (64'd1 << 32) || cabs * cabs > lim) begin
      r.st = ST_MISS;
      return r;
    end
    s = int_sqrt(lim - cabs * cabs);
    r.fx = div_sat(-(a * c) + b * s, n);
    r.fy = div_sat(-(b * c) - a * s, n);
    r.sx = div_sat(-(a * c) - b * s, n);
    r.sy = div_sat(-(b * c) + a * s, n);
    return r;
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: ctr_x = val[15:0];
      REG_CENTER_Y: ctr_y = val[15:0];
      default:      rad = val[14:0];
    endcase
  endtask

  task automatic set_circle(input int cx, input int cy, input int r);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_RADIUS, r);
  endtask

  // quiet the pipeline before touching registers
  task automatic drain;
    while (crossing_q.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  // one line transaction; expectation is queued at acceptance
  task automatic send_line(input line_row_t row);
    cross_t want;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    want = row.typed ? row.want : chord_points(row.x0, row.y0, row.x1, row.y1);
    in_tvalid <= 1'b1;
    in_tdata <= {row.y1, row.x1, row.y0, row.x0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    crossing_q.insert(crossing_q.size(), want);
    lines_sent++;
  endtask

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // mostly lines near the circle so hits dominate; some coincident and wild
  function automatic line_row_t rand_line();
    line_row_t row;
    int span, pick;
    span = 2 * int'(rad) + 64;
    pick = $urandom_range(0, 9);
    row.typed = 1'b0;
    if (pick < 7) begin
      row.x0 = clamp16(int'(ctr_x) + $urandom_range(0, 2 * span) - span);
      row.y0 = clamp16(int'(ctr_y) + $urandom_range(0, 2 * span) - span);
      row.x1 = clamp16(int'(ctr_x) + $urandom_range(0, 2 * span) - span);
      row.y1 = clamp16(int'(ctr_y) + $urandom_range(0, 2 * span) - span);
    end else begin
      row.x0 = 16'($urandom);
      row.y0 = 16'($urandom);
      row.x1 = 16'($urandom);
      row.y1 = 16'($urandom);
    end
    if (pick == 7) begin
      row.x1 = row.x0;
      row.y1 = row.y0;
    end
    return row;
  endfunction

  task automatic add_row(input int x0, y0, x1, y1, input bit typed, input cross_t want);
    line_row_t row;
    row.x0 = 16'(x0); row.y0 = 16'(y0); row.x1 = 16'(x1); row.y1 = 16'(y1);
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // result side: random stalls (none once no_idle is set), compare against oldest expectation
  initial begin
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!no_idle) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cross_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
             out_tuser};
      if (crossing_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
      end else begin
        want = crossing_q.pop_front();
        case (got.st)
          ST_HIT:  hits_seen++;
          ST_MISS: misses_seen++;
          default: sames_seen++;
        endcase
        if (got.st !== want.st)
          report($sformatf("status got %0d want %0d", got.st, want.st));
        if (got.fx !== want.fx || got.fy !== want.fy)
          report($sformatf("first point got (%0d,%0d) want (%0d,%0d)",
                           got.fx, got.fy, want.fx, want.fy));
        if (got.sx !== want.sx || got.sy !== want.sy)
          report($sformatf("second point got (%0d,%0d) want (%0d,%0d)",
                           got.sx, got.sy, want.sx, want.sy));
      end
    end
  end

  // stimulus
  initial begin
    int settings[6][3];
    cross_t z;
    z = '{fx: 0, fy: 0, sx: 0, sy: 0, st: ST_HIT};
    settings = '{'{0, 0, 32767}, '{-32768, 32767, 0}, '{32767, -32768, 32767},
                 '{-100, 50, 16}, '{0, 0, 0}, '{0, 0, 0}};
    settings[4] = '{$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(1, 32767)};
    settings[5] = '{$urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                    $urandom_range(200, 3000)};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows under the reset circle (8000, 8000), radius 1600
    add_row(0, 0, 0, 0, 1, '{0, 0, 0, 0, ST_SAME});
    add_row(-32768, 32767, -32768, 32767, 1, '{0, 0, 0, 0, ST_SAME});
    add_row(0, 0, 100, 0, 1, '{0, 0, 0, 0, ST_MISS});
    add_row(9600, 0, 9600, 100, 1, '{1600, 0, 1600, 0, ST_HIT});      // tangent
    add_row(0, 8000, 16000, 8000, 1, '{-1600, 0, 1600, 0, ST_HIT});   // diameter
    add_row(-32768, -32768, 32767, 32767, 0, z);
    add_row(32767, -32768, -32768, 32767, 0, z);
    add_row(-32768, 8000, 32767, 8000, 0, z);
    add_row(8000, -32768, 8000, 32767, 0, z);
    add_row(32767, 32767, -32768, -32768, 0, z);
    add_row(8000, 8000, 8001, 8000, 0, z);
    add_row(6400, 8000, 6400, 8001, 0, z);
    add_row(9601, 0, 9601, 100, 0, z);
    add_row(-1, -1, 0, 0, 0, z);
    foreach (dir_rows[i]) send_line(dir_rows[i]);
    for (int i = 0; i < 100; i++) send_line(rand_line());

    for (int p = 0; p < 6; p++) begin
      in_tvalid <= 1'b0;
      drain();
      set_circle(settings[p][0], settings[p][1], settings[p][2]);
      if (p == 5) no_idle = 1'b1;
      for (int i = 0; i < 150; i++) begin
        if (p == 1 && i == 60) begin
          // hold the sender until the pipeline is empty
          in_tvalid <= 1'b0;
          while (crossing_q.size() != 0) @(posedge clk);
        end
        send_line(rand_line());
      end
    end
    in_tvalid <= 1'b0;

    while (crossing_q.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    $display("Sent %0d lines over 7 circle settings (extreme centers, radius 0 and max).",
             lines_sent);
    $display("Results: %0d crossing, %0d missing, %0d coincident points.",
             hits_seen, misses_seen, sames_seen);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", crossing_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
